// ===== rtl/sspr_pkg.sv =====
// shared constants and types for the spectrum sub-packet reassembly block
package sspr_pkg;

    localparam int SLOTS_DEF     = 4;
    localparam int BINS_PER_PART = 256;
    localparam int TOTAL_BINS    = 8192;
    localparam int PARTS         = 32;
    localparam int BIN_W         = $clog2(TOTAL_BINS);

    localparam logic [31:0] FULL_MASK   = 32'hFFFF_FFFF;
    localparam logic [7:0]  LAST_OFFSET = 8'd255;

    typedef logic [1:0] func_t;
    typedef logic [2:0] status_t;

    // operation codes
    localparam func_t FUNC_WORD   = 2'd0;
    localparam func_t FUNC_RD_ACC = 2'd1;
    localparam func_t FUNC_RD_CUR = 2'd2;
    localparam func_t FUNC_CLEAR  = 2'd3;

    // result status codes
    localparam status_t ST_STORED   = 3'd0;
    localparam status_t ST_DUP      = 3'd1;
    localparam status_t ST_NOSLOT   = 3'd2;
    localparam status_t ST_PKT_DONE = 3'd3;
    localparam status_t ST_COMPLETE = 3'd4;
    localparam status_t ST_READ     = 3'd5;
    localparam status_t ST_CLEARED  = 3'd6;

endpackage

// ===== rtl/spectrum_subpacket_reassembly_top.sv =====
// top level of the spectrum sub-packet reassembly block
//
// usage: an item is taken at a rising edge with start high and busy low.
// func selects a packet count word, a read of an accumulated or current
// bin, or a clear of everything. every item gives exactly one result, shown
// for one cycle with done high; the receiver cannot hold results off.
// packet words: one item per cycle while busy stays low; the result follows
// in the cycle after the item is taken, except for a word that completes a
// spectrum. reads: the spectrum memory read and the result are registered,
// and busy is high in the read state before the result.
// a final word that completes a spectrum starts an accumulation pass: the
// 64-bit adder walks all 8192 bins, one bin per cycle through the slot
// memory and spectrum memory ports, with busy high; the complete status
// comes at its end.
// clear: one bin of both spectra zeroed per cycle, busy high, cleared status at the end.
// reset: slot tables and control are cleared at once, then the same
// clearing pass over all 8192 bins runs with busy high and no result.
// slot count memory has no reset; the user must see that entries are read
// only after written, and the block does not enforce this.
module spectrum_subpacket_reassembly_top #(
    parameter int SLOTS = sspr_pkg::SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sspr_pkg::func_t    func,
    input  logic [31:0]        seq,
    input  logic [5:0]         part,
    input  logic [7:0]         offset,
    input  logic [31:0]        count,
    input  logic [31:0]        measure_time,
    input  logic [31:0]        dead_time,
    input  logic [12:0]        bin_index,
    output logic               done,
    output sspr_pkg::status_t  status,
    output logic [31:0]        seq_out,
    output logic [31:0]        measure_time_out,
    output logic [31:0]        dead_time_out,
    output logic [63:0]        read_value
);
    import sspr_pkg::*;

    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = BIN_W + 1;
    localparam int SADDR_W    = SLOT_W + BIN_W;
    localparam int SLOT_DEPTH = SLOTS * TOTAL_BINS;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    // control state
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic              clr_report_reg, clr_report_next;
    logic              done_reg, done_next;

    // slot tables
    logic [31:0]       slot_seq_reg [SLOTS];
    logic [31:0]       slot_seq_next [SLOTS];
    logic [31:0]       slot_mask_reg [SLOTS];
    logic [31:0]       slot_mask_next [SLOTS];
    logic [SLOTS-1:0]  slot_busy_reg, slot_busy_next;
    logic [SLOT_W-1:0] active_slot_reg, active_slot_next;
    logic              dropping_reg, dropping_next;

    // payload registers
    logic [BIN_W-1:0]  pipe_idx_reg, pipe_idx_next;
    logic [SLOT_W-1:0] fin_slot_reg, fin_slot_next;
    logic              rd_sel_cur_reg, rd_sel_cur_next;
    status_t           status_reg, status_next;
    logic [31:0]       seq_out_reg, seq_out_next;
    logic [31:0]       mt_out_reg, mt_out_next;
    logic [31:0]       dt_out_reg, dt_out_next;
    logic [63:0]       rv_reg, rv_next;

    // memories
    logic [31:0]       slot_mem [SLOT_DEPTH];
    logic [63:0]       acc_mem [TOTAL_BINS];
    logic [31:0]       cur_mem [TOTAL_BINS];
    logic [31:0]       slot_rdata_reg;
    logic [63:0]       acc_rdata_reg;
    logic [31:0]       cur_rdata_reg;

    logic              slot_we;
    logic [SADDR_W-1:0] slot_waddr, slot_raddr;
    logic              acc_we, cur_we;
    logic [BIN_W-1:0]  spec_waddr, spec_raddr;
    logic [63:0]       acc_wdata;
    logic [31:0]       cur_wdata;

    // slot search
    logic [4:0]        pidx;
    logic [31:0]       part_bit;
    logic              found_vld, free_vld;
    logic [SLOT_W-1:0] found_idx, free_idx;

    assign pidx     = part[4:0] - 5'd1;   // part 0 wraps to the last part
    assign part_bit = 32'd1 << pidx;

    always_comb
    begin
        found_vld = 1'b0;
        free_vld  = 1'b0;
        found_idx = '0;
        free_idx  = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (slot_busy_reg[s] && slot_seq_reg[s] == seq && !found_vld)
            begin
                found_vld = 1'b1;
                found_idx = SLOT_W'(s);
            end
            if (!slot_busy_reg[s] && !free_vld)
            begin
                free_vld = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    // main sequencer
    always_comb
    begin
        logic              decided;
        logic              complete;
        logic              eff_drop;
        logic [SLOT_W-1:0] eff_slot;
        logic [31:0]       new_mask;
        status_t           pkt_stat;

        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pipe_vld_next    = 1'b0;
        clr_report_next  = clr_report_reg;
        done_next        = 1'b0;
        slot_seq_next    = slot_seq_reg;
        slot_mask_next   = slot_mask_reg;
        slot_busy_next   = slot_busy_reg;
        active_slot_next = active_slot_reg;
        dropping_next    = dropping_reg;
        pipe_idx_next    = pipe_idx_reg;
        fin_slot_next    = fin_slot_reg;
        rd_sel_cur_next  = rd_sel_cur_reg;
        status_next      = status_reg;
        seq_out_next     = seq_out_reg;
        mt_out_next      = mt_out_reg;
        dt_out_next      = dt_out_reg;
        rv_next          = rv_reg;

        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_raddr = {fin_slot_reg, cnt_reg[BIN_W-1:0]};
        acc_we     = 1'b0;
        cur_we     = 1'b0;
        spec_waddr = cnt_reg[BIN_W-1:0];
        spec_raddr = bin_index;
        acc_wdata  = '0;
        cur_wdata  = '0;

        decided  = 1'b0;
        complete = 1'b0;
        eff_drop = dropping_reg;
        eff_slot = active_slot_reg;
        new_mask = '0;
        pkt_stat = ST_STORED;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_RD_ACC, FUNC_RD_CUR:
                        begin
                            rd_sel_cur_next = (func == FUNC_RD_CUR);
                            state_next      = S_READ;
                        end
                        FUNC_CLEAR:
                        begin
                            for (int s = 0; s < SLOTS; s++)
                            begin
                                slot_seq_next[s]  = '0;
                                slot_mask_next[s] = '0;
                            end
                            slot_busy_next   = '0;
                            active_slot_next = '0;
                            dropping_next    = 1'b1;
                            cnt_next         = '0;
                            clr_report_next  = 1'b1;
                            state_next       = S_CLR;
                        end
                        default:
                        begin
                            // first word opens a packet: match a slot or claim a free one
                            if (offset == 8'd0)
                            begin
                                eff_drop = 1'b1;
                                if (found_vld)
                                begin
                                    if ((slot_mask_reg[found_idx] & part_bit) != '0)
                                    begin
                                        pkt_stat = ST_DUP;
                                        decided  = 1'b1;
                                    end
                                    else
                                    begin
                                        eff_slot = found_idx;
                                        eff_drop = 1'b0;
                                    end
                                end
                                else if (free_vld)
                                begin
                                    eff_slot                 = free_idx;
                                    slot_busy_next[free_idx] = 1'b1;
                                    slot_seq_next[free_idx]  = seq;
                                    slot_mask_next[free_idx] = '0;
                                    eff_drop                 = 1'b0;
                                end
                                else
                                begin
                                    pkt_stat = ST_NOSLOT;
                                    decided  = 1'b1;
                                end
                            end
                            if (!decided)
                            begin
                                if (eff_drop || !slot_busy_next[eff_slot])
                                begin
                                    eff_drop = 1'b1;
                                    pkt_stat = ST_NOSLOT;
                                end
                                else
                                begin
                                    slot_we    = 1'b1;
                                    slot_waddr = {eff_slot, pidx, offset};
                                    pkt_stat   = ST_STORED;
                                    if (offset == LAST_OFFSET)
                                    begin
                                        eff_drop = 1'b1;
                                        new_mask = slot_mask_next[eff_slot] | part_bit;
                                        slot_mask_next[eff_slot] = new_mask;
                                        pkt_stat = ST_PKT_DONE;
                                        if (new_mask == FULL_MASK)
                                        begin
                                            // spectrum complete: free the slot, start the pass
                                            complete     = 1'b1;
                                            seq_out_next = slot_seq_next[eff_slot];
                                            mt_out_next  = measure_time;
                                            dt_out_next  = dead_time;
                                            slot_busy_next[eff_slot] = 1'b0;
                                            slot_mask_next[eff_slot] = '0;
                                            slot_seq_next[eff_slot]  = '0;
                                            fin_slot_next = eff_slot;
                                            cnt_next      = '0;
                                            state_next    = S_FIN;
                                        end
                                    end
                                end
                            end
                            dropping_next    = eff_drop;
                            active_slot_next = eff_slot;
                            rv_next          = '0;
                            if (complete)
                            begin
                                status_next = ST_COMPLETE;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                status_next  = pkt_stat;
                                seq_out_next = '0;
                                mt_out_next  = '0;
                                dt_out_next  = '0;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next    = 1'b1;
                status_next  = ST_READ;
                seq_out_next = '0;
                mt_out_next  = '0;
                dt_out_next  = '0;
                rv_next      = rd_sel_cur_reg ? {32'd0, cur_rdata_reg} : acc_rdata_reg;
                state_next   = S_IDLE;
            end
            S_FIN:
            begin
                // issue bin i while bin i-1 is added and written back
                spec_raddr = cnt_reg[BIN_W-1:0];
                if (cnt_reg != CNT_W'(TOTAL_BINS))
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[BIN_W-1:0];
                end
                if (pipe_vld_reg)
                begin
                    acc_we     = 1'b1;
                    cur_we     = 1'b1;
                    spec_waddr = pipe_idx_reg;
                    acc_wdata  = acc_rdata_reg + {32'd0, slot_rdata_reg};
                    cur_wdata  = slot_rdata_reg;
                end
                if (cnt_reg == CNT_W'(TOTAL_BINS) && !pipe_vld_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                acc_we     = 1'b1;
                cur_we     = 1'b1;
                spec_waddr = cnt_reg[BIN_W-1:0];
                if (cnt_reg == CNT_W'(TOTAL_BINS - 1))
                begin
                    // reset pass ends silently, a clear item reports
                    if (clr_report_reg)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_CLEARED;
                        seq_out_next = '0;
                        mt_out_next  = '0;
                        dt_out_next  = '0;
                        rv_next      = '0;
                    end
                    clr_report_next = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            cnt_reg         <= '0;
            pipe_vld_reg    <= 1'b0;
            clr_report_reg  <= 1'b0;
            done_reg        <= 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_seq_reg[s]  <= '0;
                slot_mask_reg[s] <= '0;
            end
            slot_busy_reg   <= '0;
            active_slot_reg <= '0;
            dropping_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pipe_vld_reg    <= pipe_vld_next;
            clr_report_reg  <= clr_report_next;
            done_reg        <= done_next;
            slot_seq_reg    <= slot_seq_next;
            slot_mask_reg   <= slot_mask_next;
            slot_busy_reg   <= slot_busy_next;
            active_slot_reg <= active_slot_next;
            dropping_reg    <= dropping_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= pipe_idx_next;
        fin_slot_reg   <= fin_slot_next;
        rd_sel_cur_reg <= rd_sel_cur_next;
        status_reg     <= status_next;
        seq_out_reg    <= seq_out_next;
        mt_out_reg     <= mt_out_next;
        dt_out_reg     <= dt_out_next;
        rv_reg         <= rv_next;
    end

    // slot count memory
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= count;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    // accumulated spectrum memory
    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[spec_waddr] <= acc_wdata;
        end
        acc_rdata_reg <= acc_mem[spec_raddr];
    end

    // current spectrum memory
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[spec_waddr] <= cur_wdata;
        end
        cur_rdata_reg <= cur_mem[spec_raddr];
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign seq_out          = seq_out_reg;
    assign measure_time_out = mt_out_reg;
    assign dead_time_out    = dt_out_reg;
    assign read_value       = rv_reg;

endmodule

// ===== rtl/sspr_checker.sv =====
// port-level checks for the spectrum sub-packet reassembly block
module sspr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input sspr_pkg::func_t    func,
    input logic [7:0]         offset,
    input logic               done,
    input sspr_pkg::status_t  status,
    input logic [31:0]        seq_out,
    input logic [31:0]        measure_time_out,
    input logic [31:0]        dead_time_out,
    input logic [63:0]        read_value
);
    import sspr_pkg::*;

    // a read raises busy, then reports in the following cycle
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == FUNC_RD_ACC || func == FUNC_RD_CUR)
        |=> busy ##1 (done && status == ST_READ))
        else $error("read item did not report on time");

    // a non-final packet word reports in the next cycle
    a_word_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FUNC_WORD && offset != LAST_OFFSET
        |=> done && (status == ST_STORED || status == ST_DUP || status == ST_NOSLOT))
        else $error("packet word result missing or wrong status");

    // clear holds busy through its pass
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FUNC_CLEAR |=> busy ##1 busy)
        else $error("clear did not hold busy");

    // completion fields only on a complete status
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_COMPLETE
        |-> seq_out == '0 && measure_time_out == '0 && dead_time_out == '0)
        else $error("completion fields set on other status");

    // read value only on a read status
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_READ |-> read_value == '0)
        else $error("read value set on other status");

endmodule

bind spectrum_subpacket_reassembly_top sspr_checker u_sspr_checker (.*);

// ===== test/tb_spectrum_subpacket_reassembly_top.sv =====
// self-checking testbench for the spectrum sub-packet reassembly block
module tb_spectrum_subpacket_reassembly_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sspr_pkg::*;

    localparam int NSLOT      = SLOTS_DEF;
    localparam int LIVE       = 3;      // spectra being built at once in the random part
    localparam int CLEAR_CAP  = 40;     // each clear costs a full pass over the bins
    localparam int PHASE_ITEMS = 650;

    // one input item, field for field as on the ports
    typedef struct packed {
        func_t       func;
        logic [31:0] seq;
        logic [5:0]  part;
        logic [7:0]  offset;
        logic [31:0] count;
        logic [31:0] mtime;
        logic [31:0] dtime;
        logic [12:0] bin;
    } item_t;

    // one result, in port order
    typedef struct packed {
        status_t     status;
        logic [31:0] seq;
        logic [31:0] mtime;
        logic [31:0] dtime;
        logic [63:0] value;
    } result_t;

    // mirror of the slot tables and both spectra; each accepted item yields
    // exactly one awaited result, checked in order against what the block shows
    class reassembly_tracker;
        logic [31:0] slot_seq  [NSLOT];
        logic [31:0] slot_mask [NSLOT];
        logic        slot_busy [NSLOT];
        logic [31:0] slot_mem  [NSLOT*TOTAL_BINS];
        logic [63:0] acc_spec  [TOTAL_BINS];
        logic [31:0] cur_spec  [TOTAL_BINS];
        int          open_slot;
        logic        pkt_closed;
        result_t     awaited[$];
        result_t     last_pred;
        int          n_checked;
        int          n_errors;
        int          n_complete;
        int          n_drop;
        int          n_read;
        int          n_clear;

        function new();
            foreach (slot_mem[i])
                slot_mem[i] = '0;
            wipe();
            // after reset no packet is open, yet the next word is not marked dropped
            pkt_closed = 1'b0;
            n_checked = 0;
            n_errors = 0;
            n_complete = 0;
            n_drop = 0;
            n_read = 0;
            n_clear = 0;
        endfunction

        function void wipe();
            foreach (acc_spec[i])
            begin
                acc_spec[i] = '0;
                cur_spec[i] = '0;
            end
            foreach (slot_seq[s])
            begin
                slot_seq[s] = '0;
                slot_mask[s] = '0;
                slot_busy[s] = 1'b0;
            end
            open_slot = 0;
            pkt_closed = 1'b1;
        endfunction

        function void take_item(item_t it);
            result_t     r;
            int          pidx;
            int          hit;
            int          vacant;
            int          base;
            logic [31:0] part_bit;
            logic        settled;
            r = '0;
            settled = 1'b0;
            // part numbers wrap: part 0 is the 32nd, part 33 the first
            pidx = (int'(it.part) + PARTS - 1) % PARTS;
            part_bit = 32'd1 << pidx;
            case (it.func)
                FUNC_RD_ACC:
                begin
                    r.status = ST_READ;
                    r.value = acc_spec[it.bin];
                end
                FUNC_RD_CUR:
                begin
                    r.status = ST_READ;
                    r.value = {32'd0, cur_spec[it.bin]};
                end
                FUNC_CLEAR:
                begin
                    wipe();
                    r.status = ST_CLEARED;
                end
                default:
                begin
                    r.status = ST_STORED;
                    if (it.offset == 8'd0)
                    begin
                        // opening word: own slot by sequence, else lowest free one
                        hit = -1;
                        vacant = -1;
                        foreach (slot_busy[s])
                        begin
                            if (slot_busy[s] && slot_seq[s] == it.seq && hit < 0)
                                hit = s;
                            if (!slot_busy[s] && vacant < 0)
                                vacant = s;
                        end
                        pkt_closed = 1'b1;
                        if (hit >= 0)
                        begin
                            if ((slot_mask[hit] & part_bit) != 0)
                                r.status = ST_DUP;
                            else
                            begin
                                open_slot = hit;
                                pkt_closed = 1'b0;
                            end
                        end
                        else if (vacant >= 0)
                        begin
                            open_slot = vacant;
                            slot_busy[vacant] = 1'b1;
                            slot_seq[vacant] = it.seq;
                            slot_mask[vacant] = '0;
                            pkt_closed = 1'b0;
                        end
                        else
                            r.status = ST_NOSLOT;
                        settled = (r.status != ST_STORED);
                    end
                    if (!settled)
                    begin
                        if (pkt_closed || !slot_busy[open_slot])
                        begin
                            pkt_closed = 1'b1;
                            r.status = ST_NOSLOT;
                        end
                        else
                        begin
                            base = open_slot * TOTAL_BINS;
                            slot_mem[base + pidx * BINS_PER_PART + int'(it.offset)] = it.count;
                            if (it.offset == LAST_OFFSET)
                            begin
                                pkt_closed = 1'b1;
                                slot_mask[open_slot] |= part_bit;
                                r.status = ST_PKT_DONE;
                                if (slot_mask[open_slot] == FULL_MASK)
                                begin
                                    // last part in: fold the slot into both spectra, free it
                                    r.status = ST_COMPLETE;
                                    r.seq = slot_seq[open_slot];
                                    r.mtime = it.mtime;
                                    r.dtime = it.dtime;
                                    for (int i = 0; i < TOTAL_BINS; i++)
                                    begin
                                        acc_spec[i] = acc_spec[i] + {32'd0, slot_mem[base + i]};
                                        cur_spec[i] = slot_mem[base + i];
                                    end
                                    slot_busy[open_slot] = 1'b0;
                                    slot_mask[open_slot] = '0;
                                    slot_seq[open_slot] = '0;
                                end
                            end
                        end
                    end
                end
            endcase
            case (r.status)
                ST_COMPLETE: n_complete++;
                ST_DUP:      n_drop++;
                ST_NOSLOT:   n_drop++;
                ST_READ:     n_read++;
                ST_CLEARED:  n_clear++;
                default:     ;
            endcase
            last_pred = r;
            awaited.push_back(r);
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                if (n_errors < 10)
                    $display("result with nothing awaited: status %0d seq %h value %h",
                             got.status, got.seq, got.value);
                n_errors++;
                return;
            end
            want = awaited.pop_front();
            n_checked++;
            if (got.status !== want.status || got.seq !== want.seq || got.mtime !== want.mtime
                || got.dtime !== want.dtime || got.value !== want.value)
            begin
                if (n_errors < 10)
                begin
                    $display("mismatch at result %0d (t=%0t)", n_checked, $realtime);
                    $display("  expected status %0d seq %h mtime %h dtime %h value %h",
                             want.status, want.seq, want.mtime, want.dtime, want.value);
                    $display("  actual   status %0d seq %h mtime %h dtime %h value %h",
                             got.status, got.seq, got.mtime, got.dtime, got.value);
                end
                n_errors++;
            end
        endfunction

        function logic [31:0] mask_for(logic [31:0] s);
            foreach (slot_busy[i])
                if (slot_busy[i] && slot_seq[i] == s)
                    return slot_mask[i];
            return '0;
        endfunction

        function bit room_for(logic [31:0] s);
            foreach (slot_busy[i])
                if (!slot_busy[i] || slot_seq[i] == s)
                    return 1'b1;
            return 1'b0;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    func_t       func = FUNC_WORD;
    logic [31:0] seq = '0;
    logic [5:0]  part = '0;
    logic [7:0]  offset = '0;
    logic [31:0] count = '0;
    logic [31:0] measure_time = '0;
    logic [31:0] dead_time = '0;
    logic [12:0] bin_index = '0;
    logic        done;
    status_t     status;
    logic [31:0] seq_out;
    logic [31:0] measure_time_out;
    logic [31:0] dead_time_out;
    logic [63:0] read_value;

    reassembly_tracker tracker;
    int          idle_pct = 30;     // chance in a hundred that the sender holds off a cycle
    int          n_items = 0;
    int          n_clears = 0;
    logic [31:0] live_seq [LIVE];

    spectrum_subpacket_reassembly_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .seq              (seq),
        .part             (part),
        .offset           (offset),
        .count            (count),
        .measure_time     (measure_time),
        .dead_time        (dead_time),
        .bin_index        (bin_index),
        .done             (done),
        .status           (status),
        .seq_out          (seq_out),
        .measure_time_out (measure_time_out),
        .dead_time_out    (dead_time_out),
        .read_value       (read_value)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // results live one cycle and cannot be held off; sampled at the edge ending that cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.match_result({status, seq_out, measure_time_out, dead_time_out, read_value});
    end

    // present one item, hold it until an edge sees start high and busy low
    task automatic send(item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        func         <= it.func;
        seq          <= it.seq;
        part         <= it.part;
        offset       <= it.offset;
        count        <= it.count;
        measure_time <= it.mtime;
        dead_time    <= it.dtime;
        bin_index    <= it.bin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.take_item(it);
        n_items++;
        if (it.func == FUNC_CLEAR)
            n_clears++;
    endtask

    // sender stops until every awaited result has been seen
    task automatic wait_drained();
        start <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
    endtask

    // every field random at full width
    function automatic item_t noise_item();
        item_t it;
        it.func   = func_t'($urandom_range(3));
        it.seq    = $urandom;
        it.part   = 6'($urandom_range(63));
        it.offset = 8'($urandom_range(255));
        it.count  = $urandom;
        it.mtime  = $urandom;
        it.dtime  = $urandom;
        it.bin    = 13'($urandom);
        return it;
    endfunction

    function automatic item_t word_item(logic [31:0] s, logic [5:0] p, logic [7:0] o);
        item_t it;
        int    pick;
        it = noise_item();
        it.func = FUNC_WORD;
        it.seq = s;
        it.part = p;
        it.offset = o;
        // counts lean toward the extremes now and then
        pick = $urandom_range(15);
        if (pick == 0)
            it.count = '0;
        else if (pick == 1)
            it.count = 32'hFFFF_FFFF;
        return it;
    endfunction

    function automatic item_t read_item(func_t f, logic [12:0] b);
        item_t it;
        it = noise_item();
        it.func = f;
        it.bin = b;
        return it;
    endfunction

    function automatic item_t clear_item();
        item_t it;
        it = noise_item();
        it.func = FUNC_CLEAR;
        return it;
    endfunction

    // part index to port code, sometimes through its wrapped alias
    function automatic logic [5:0] part_code(int pidx);
        if ($urandom_range(9) == 0)
            return (pidx == PARTS - 1) ? 6'd0 : 6'(pidx + PARTS + 1);
        return 6'(pidx + 1);
    endfunction

    // short packet: opening word, a few rising offsets, closing word unless cut
    task automatic send_packet(logic [31:0] pseq, int pidx, int middle, bit cut);
        logic [5:0] pc;
        int         off;
        pc = part_code(pidx);
        send(word_item(pseq, pc, 8'd0));
        off = 0;
        for (int k = 0; k < middle && off < 254; k++)
        begin
            off = $urandom_range(off + 1, (off + 60 > 254) ? 254 : off + 60);
            send(word_item(pseq, pc, 8'(off)));
        end
        if (!cut)
            send(word_item(pseq, pc, LAST_OFFSET));
    endtask

    task automatic random_phase(int pct, int quota);
        int          stop_at;
        int          pick;
        int          li;
        int          pidx;
        logic [31:0] have;
        item_t       it;
        idle_pct = pct;
        stop_at = n_items + quota;
        while (n_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                // mostly push the lead spectrum toward completion
                li = ($urandom_range(9) < 7) ? 0 : $urandom_range(LIVE - 1);
                if (!tracker.room_for(live_seq[li]) && $urandom_range(9) < 3
                    && n_clears < CLEAR_CAP)
                    send(clear_item());
                else
                begin
                    have = tracker.mask_for(live_seq[li]);
                    pidx = $urandom_range(PARTS - 1);
                    // most packets carry a part still missing, the rest may repeat one
                    if ($urandom_range(99) < 85 && have != FULL_MASK)
                        while (have[pidx])
                            pidx = $urandom_range(PARTS - 1);
                    send_packet(live_seq[li], pidx, $urandom_range(4), $urandom_range(9) == 0);
                    if (tracker.last_pred.status == ST_COMPLETE)
                        live_seq[li] = $urandom;
                end
            end
            else if (pick < 84)
            begin
                it = noise_item();
                it.func = ($urandom_range(1) == 0) ? FUNC_RD_ACC : FUNC_RD_CUR;
                if ($urandom_range(7) == 0)
                    it.bin = ($urandom_range(1) == 0) ? 13'd0 : 13'h1FFF;
                send(it);
            end
            else if (pick < 97)
            begin
                // stray items; half aimed at a live spectrum to break its packets
                it = noise_item();
                if (it.func == FUNC_CLEAR && ($urandom_range(19) != 0 || n_clears >= CLEAR_CAP))
                    it.func = FUNC_RD_ACC;
                if ($urandom_range(1) == 0)
                begin
                    it.func = FUNC_WORD;
                    it.seq = live_seq[$urandom_range(LIVE - 1)];
                    case ($urandom_range(2))
                        0:       it.offset = 8'd0;
                        1:       it.offset = LAST_OFFSET;
                        default: ;
                    endcase
                end
                send(it);
            end
            else
                // intruder spectrum, competes for a slot
                send_packet($urandom, $urandom_range(PARTS - 1), $urandom_range(2), 1'b0);
        end
    endtask

    initial
    begin
        logic [31:0] base;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh block: empty spectra, a word with no packet open, a clear
        send(read_item(FUNC_RD_ACC, 13'd0));
        send(read_item(FUNC_RD_CUR, 13'h1FFF));
        send(word_item(32'hFFFF_FFFF, 6'd1, 8'd7));
        send(clear_item());

        // four full spectra interleaved part by part, one per slot, so every
        // slot memory entry is written before any short packet completes there
        base = $urandom;
        for (int p = 0; p < PARTS; p++)
            for (int s = 0; s < NSLOT; s++)
                for (int o = 0; o < BINS_PER_PART; o++)
                    send(word_item(base + s, 6'(p + 1), 8'(o)));
        wait_drained();

        // bins at both ends and the top index bit
        send(read_item(FUNC_RD_ACC, 13'h1FFF));
        send(read_item(FUNC_RD_CUR, 13'd0));
        send(read_item(FUNC_RD_ACC, 13'h1000));
        // part 0 stands for part 32; a second open of it is a duplicate
        send(word_item(32'hFFFF_FFFF, 6'd0, 8'd0));
        send(word_item(32'hFFFF_FFFF, 6'd0, LAST_OFFSET));
        send(word_item(32'hFFFF_FFFF, 6'd32, 8'd0));
        send(word_item(32'hFFFF_FFFF, 6'd32, LAST_OFFSET));
        // part 33 wraps to part 1; reopening drops it without its bit
        send(word_item(32'd0, 6'd33, 8'd0));
        send(word_item(32'd0, 6'd63, 8'd0));
        send(word_item(32'd0, 6'd63, LAST_OFFSET));
        send(word_item(32'd0, 6'd1, 8'd10));
        // fill the last two slots, then one spectrum too many
        send(word_item(32'd1, 6'd5, 8'd0));
        send(word_item(32'd2, 6'd5, 8'd0));
        send(word_item(32'd3, 6'd5, 8'd0));
        send(word_item(32'd3, 6'd5, 8'd1));
        send(clear_item());
        send(read_item(FUNC_RD_ACC, 13'h1FFF));
        wait_drained();

        foreach (live_seq[i])
            live_seq[i] = $urandom;
        random_phase(30, PHASE_ITEMS);
        wait_drained();
        random_phase(77, PHASE_ITEMS);
        wait_drained();
        random_phase(0, PHASE_ITEMS);

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d items, %0d results checked: %0d spectra completed, %0d drops",
                 n_items, tracker.n_checked, tracker.n_complete, tracker.n_drop);
        $display("  %0d bin reads, %0d clears, %0d mismatches",
                 tracker.n_read, tracker.n_clear, tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hang guard, several times the slowest expected run
    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

endmodule
